// ===== rtl/ncle_pkg.sv =====
package ncle_pkg;

   // Event codes carried in the low bits of req_tuser
   localparam logic [2:0] FUNC_WRITE  = 3'd0;
   localparam logic [2:0] FUNC_TICK   = 3'd1;
   localparam logic [2:0] FUNC_ENV    = 3'd2;
   localparam logic [2:0] FUNC_LEN    = 3'd3;
   localparam logic [2:0] FUNC_ENABLE = 3'd4;

   // Register numbers for FUNC_WRITE
   localparam logic [1:0] REG_CTRL   = 2'd0;
   localparam logic [1:0] REG_UNUSED = 2'd1;
   localparam logic [1:0] REG_PERIOD = 2'd2;
   localparam logic [1:0] REG_LENGTH = 2'd3;

   localparam logic [3:0] DECAY_MAX = 4'hF;

   typedef struct packed {
      logic [2:0] func;
      logic [1:0] reg_index;
      logic [7:0] reg_value;
   } ncle_event_type;

   typedef struct packed {
      logic       length_active;
      logic [3:0] level;
   } ncle_result_type;

   // Noise timer period table (NTSC)
   function automatic logic [11:0] period_lookup(input logic [3:0] sel);
      logic [11:0] p;
      case (sel)
         4'd0:    p = 12'd4;
         4'd1:    p = 12'd8;
         4'd2:    p = 12'd16;
         4'd3:    p = 12'd32;
         4'd4:    p = 12'd64;
         4'd5:    p = 12'd96;
         4'd6:    p = 12'd128;
         4'd7:    p = 12'd160;
         4'd8:    p = 12'd202;
         4'd9:    p = 12'd254;
         4'd10:   p = 12'd380;
         4'd11:   p = 12'd508;
         4'd12:   p = 12'd762;
         4'd13:   p = 12'd1016;
         4'd14:   p = 12'd2034;
         default: p = 12'd4068;
      endcase
      return p;
   endfunction

   // Length counter load table
   function automatic logic [7:0] length_lookup(input logic [4:0] sel);
      logic [7:0] n;
      case (sel)
         5'd0:    n = 8'd10;
         5'd1:    n = 8'd254;
         5'd2:    n = 8'd20;
         5'd3:    n = 8'd2;
         5'd4:    n = 8'd40;
         5'd5:    n = 8'd4;
         5'd6:    n = 8'd80;
         5'd7:    n = 8'd6;
         5'd8:    n = 8'd160;
         5'd9:    n = 8'd8;
         5'd10:   n = 8'd60;
         5'd11:   n = 8'd10;
         5'd12:   n = 8'd14;
         5'd13:   n = 8'd12;
         5'd14:   n = 8'd26;
         5'd15:   n = 8'd14;
         5'd16:   n = 8'd12;
         5'd17:   n = 8'd16;
         5'd18:   n = 8'd24;
         5'd19:   n = 8'd18;
         5'd20:   n = 8'd48;
         5'd21:   n = 8'd20;
         5'd22:   n = 8'd96;
         5'd23:   n = 8'd22;
         5'd24:   n = 8'd192;
         5'd25:   n = 8'd24;
         5'd26:   n = 8'd72;
         5'd27:   n = 8'd26;
         5'd28:   n = 8'd16;
         5'd29:   n = 8'd28;
         5'd30:   n = 8'd32;
         default: n = 8'd30;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/ncle_core.sv =====
module ncle_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  ncle_pkg::ncle_event_type  evt,
   output ncle_pkg::ncle_result_type result
);
   import ncle_pkg::*;

   logic        halt_loop_ff,     halt_loop_in;
   logic        const_vol_ff,     const_vol_in;
   logic [3:0]  vol_period_ff,    vol_period_in;
   logic        short_mode_ff,    short_mode_in;
   logic [11:0] period_reload_ff, period_reload_in;
   logic [11:0] period_count_ff,  period_count_in;
   logic [7:0]  length_count_ff,  length_count_in;
   logic        env_start_ff,     env_start_in;
   logic [3:0]  decay_ff,         decay_in;
   logic [3:0]  env_divider_ff,   env_divider_in;
   logic [14:0] lfsr_ff,          lfsr_in;
   logic        half_phase_ff,    half_phase_in;
   logic        chan_enabled_ff,  chan_enabled_in;
   logic        feedback;
   logic        tick;

   assign tick     = step && (evt.func == FUNC_TICK);
   // short mode taps bit 6 instead of bit 1
   assign feedback = lfsr_ff[0] ^ (short_mode_ff ? lfsr_ff[6] : lfsr_ff[1]);

   always_comb begin
      halt_loop_in     = halt_loop_ff;
      const_vol_in     = const_vol_ff;
      vol_period_in    = vol_period_ff;
      short_mode_in    = short_mode_ff;
      period_reload_in = period_reload_ff;
      period_count_in  = period_count_ff;
      length_count_in  = length_count_ff;
      env_start_in     = env_start_ff;
      decay_in         = decay_ff;
      env_divider_in   = env_divider_ff;
      lfsr_in          = lfsr_ff;
      half_phase_in    = half_phase_ff;
      chan_enabled_in  = chan_enabled_ff;
      if (step) begin
         case (evt.func)
            FUNC_WRITE: begin
               case (evt.reg_index)
                  REG_CTRL: begin
                     halt_loop_in  = evt.reg_value[5];
                     const_vol_in  = evt.reg_value[4];
                     vol_period_in = evt.reg_value[3:0];
                  end
                  REG_PERIOD: begin
                     short_mode_in    = evt.reg_value[7];
                     period_reload_in = period_lookup(evt.reg_value[3:0]);
                  end
                  REG_LENGTH: begin
                     if (chan_enabled_ff) begin
                        length_count_in = length_lookup(evt.reg_value[7:3]);
                     end
                     env_start_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            FUNC_TICK: begin
               if (!chan_enabled_ff) begin
                  length_count_in = '0;
               end
               half_phase_in = !half_phase_ff;
               // timer steps on the tick that sets the phase bit
               if (!half_phase_ff) begin
                  if (period_count_ff == '0) begin
                     period_count_in = period_reload_ff;
                     lfsr_in         = {feedback, lfsr_ff[14:1]};
                  end else begin
                     period_count_in = period_count_ff - 12'd1;
                  end
               end
            end
            FUNC_ENV: begin
               if (env_start_ff) begin
                  env_start_in   = 1'b0;
                  decay_in       = DECAY_MAX;
                  env_divider_in = vol_period_ff;
               end else if (env_divider_ff == '0) begin
                  env_divider_in = vol_period_ff;
                  if (decay_ff != '0) begin
                     decay_in = decay_ff - 4'd1;
                  end else if (halt_loop_ff) begin
                     decay_in = DECAY_MAX;
                  end
               end else begin
                  env_divider_in = env_divider_ff - 4'd1;
               end
            end
            FUNC_LEN: begin
               if (length_count_ff != '0 && !halt_loop_ff) begin
                  length_count_in = length_count_ff - 8'd1;
               end
            end
            FUNC_ENABLE: begin
               chan_enabled_in = evt.reg_value[0];
               if (!evt.reg_value[0]) begin
                  length_count_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result reflects the state after this beat's event
   always_comb begin
      result.length_active = (length_count_in != '0);
      result.level         = '0;
      if (length_count_in != '0 && !lfsr_in[0]) begin
         result.level = const_vol_in ? vol_period_in : decay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_loop_ff     <= 1'b0;
         const_vol_ff     <= 1'b0;
         vol_period_ff    <= '0;
         short_mode_ff    <= 1'b0;
         period_reload_ff <= '0;
         period_count_ff  <= '0;
         length_count_ff  <= '0;
         env_start_ff     <= 1'b0;
         decay_ff         <= '0;
         env_divider_ff   <= '0;
         lfsr_ff          <= 15'd1;
         half_phase_ff    <= 1'b0;
         chan_enabled_ff  <= 1'b0;
      end else begin
         halt_loop_ff     <= halt_loop_in;
         const_vol_ff     <= const_vol_in;
         vol_period_ff    <= vol_period_in;
         short_mode_ff    <= short_mode_in;
         period_reload_ff <= period_reload_in;
         period_count_ff  <= period_count_in;
         length_count_ff  <= length_count_in;
         env_start_ff     <= env_start_in;
         decay_ff         <= decay_in;
         env_divider_ff   <= env_divider_in;
         lfsr_ff          <= lfsr_in;
         half_phase_ff    <= half_phase_in;
         chan_enabled_ff  <= chan_enabled_in;
      end
   end

   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("noise LFSR reached the all-zero lockup state");

   a_disabled_silent: assert property (@(posedge clock) disable iff (reset)
      !chan_enabled_ff |-> length_count_ff == '0)
      else $error("length counter loaded while channel disabled");

   a_phase_toggle: assert property (@(posedge clock) disable iff (reset)
      tick |=> half_phase_ff != $past(half_phase_ff))
      else $error("half phase did not toggle on cpu tick");

endmodule

// ===== rtl/noise_channel_lfsr_envelope.sv =====
// Noise voice: 15-bit LFSR gated by a length counter, scaled by a decaying
// envelope or a constant volume.
//
// req_*  : one beat per event. tuser carries the event code and register
//          number, tdata the written byte (bit 0 for an enable write).
// rsp_*  : exactly one beat per event, carrying the level and length status
//          as they stand after that event.
//
// A beat taken into the input register moves on to the result register and
// then shows on rsp_*. Throughput: one event per cycle while rsp_tready is
// high; the input register and the result register each hold one beat, and
// every event updates the voice state in combinational logic between them.
// Stall: while rsp_tready is low the result register holds its beat; one more
// event may be taken into the input register, after which req_tready drops
// until the result is taken.
// Reset (synchronous, active high): both registers empty, voice state cleared,
// LFSR seeded with 1, channel disabled.
module noise_channel_lfsr_envelope (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] reg_value
   input  logic [4:0] req_tuser,   // [2:0] func, [4:3] reg_index
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [3:0] level, [4] length_active, [7:5] zero
);
   import ncle_pkg::*;

   logic            in_valid_ff,  in_valid_in;
   ncle_event_type  in_event_ff;
   logic            out_valid_ff, out_valid_in;
   ncle_result_type out_result_ff;
   ncle_result_type core_result;
   logic            advance;
   logic            req_beat;

   // move the held event through the voice when the result slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   ncle_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .evt    (in_event_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_event_ff.func      <= req_tuser[2:0];
         in_event_ff.reg_index <= req_tuser[4:3];
         in_event_ff.reg_value <= req_tdata;
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff.length_active, out_result_ff.level};

   a_silent_when_idle_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_result_ff.length_active |-> out_result_ff.level == '0)
      else $error("nonzero level with length counter at zero");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule
